>>> hw/rtl/epr_pkg.sv
// Package for the entropy pool random number generator.
// Holds sizes, constants, op codes, controller states, the command and status structs and the LFSR step function.
// No dependencies.
package epr_pkg;

  localparam int unsigned PoolDepth = 32;
  localparam int unsigned SlotW = $clog2(PoolDepth);
  localparam int unsigned MaxDraws = 64;
  localparam int unsigned DrawW = $clog2(MaxDraws) + 1;

  localparam logic [31:0] LfsrTaps = 32'hB4BC_D35C;
  localparam logic [31:0] LfsrSeed = 32'hDEAD_1337;
  localparam logic [31:0] Golden = 32'h9E37_79B9;
  localparam logic [31:0] MixMul = 32'h045D_9F3B;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpRandom = 2'd1,
    OpRange = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    StInit,
    StIdle,
    StAddA,
    StAddB,
    StThrStart,
    StThrWait,
    StFoldStart,
    StFold,
    StFoldLast,
    StWriteBack,
    StMix1,
    StMix2,
    StCheck,
    StModStart,
    StModWait,
    StOut
  } state_e;

  typedef struct packed {
    logic init_step;
    logic latch_in;
    logic add_a;
    logic add_b;
    logic thr_start;
    logic fold_start;
    logic fold_acc;
    logic write_back;
    logic mix1;
    logic mix2;
    logic mod_start;
    logic draw_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic fold_last;
    logic div_done;
    logic accept_draw;
    logic bound_small;
  } status_t;

  function automatic logic [31:0] lfsr_advance(input logic [31:0] w);
    logic [31:0] s;
    s = {1'b0, w[31:1]};
    if (w[0]) begin
      s = s ^ LfsrTaps;
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/epr_divider.sv
// Restoring radix-2 divider producing a 32-bit remainder, one bit per cycle.
// Depends on epr_pkg.
module epr_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import epr_pkg::*;

  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q[31:0], quo_q[31]};
  assign diff = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (!diff[32]) begin
        rem_d = diff;
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q[31:0];
endmodule

>>> hw/rtl/epr_datapath.sv
// Datapath: pool memory, LFSR, slot pointer, fold accumulator, mixer and remainder unit.
// Depends on epr_pkg and epr_divider.
module epr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  epr_pkg::cmd_t     cmd_i,
  output epr_pkg::status_t  status_o,
  input  logic [1:0]        op_i,
  input  logic [31:0]       sample_i,
  input  logic [31:0]       uptime_ms_i,
  input  logic [31:0]       bound_i,
  output logic [31:0]       random_word_o
);
  import epr_pkg::*;

  logic [31:0] mem [PoolDepth];
  logic [31:0] rd_q;
  logic [SlotW-1:0] rd_addr;
  logic wr_en;
  logic [SlotW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic [31:0] lfsr_q, lfsr_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW:0] init_q, init_d;
  logic [SlotW-1:0] scan_q, scan_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] val_q, val_d;
  logic [31:0] bound_q, thr_q, thr_d;
  logic [31:0] out_q, out_d;
  logic [31:0] mixed;
  logic [31:0] prod;
  logic div_start, div_done;
  logic [31:0] div_a, div_b, rem;
  logic [31:0] init_word;
  logic [SlotW-1:0] slot_nx;

  assign slot_nx = slot_q + 1'b1;

  // Memory reads are registered; the fold scans addresses in order.
  always_comb begin
    rd_addr = scan_q;
    if (cmd_i.add_a) begin
      rd_addr = slot_nx;
    end else if (cmd_i.latch_in) begin
      rd_addr = slot_q;
    end else if (cmd_i.fold_acc && scan_q == '0) begin
      // The last fold cycle fetches the current slot for the write-back.
      rd_addr = slot_q;
    end
  end

  assign init_word = lfsr_advance(lfsr_q) ^ (32'(init_q) * Golden);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = slot_q;
    wr_data = '0;
    if (cmd_i.init_step) begin
      wr_en = 1'b1;
      wr_addr = init_q[SlotW-1:0];
      unique case (init_q[SlotW-1:0])
        SlotW'(0): wr_data = 32'hCAFE_BABE;
        SlotW'(1): wr_data = 32'h3141_5926;
        SlotW'(2): wr_data = 32'hABCD_EF01;
        SlotW'(3): wr_data = 32'h8765_4321;
        default: wr_data = init_word;
      endcase
    end else if (cmd_i.add_a) begin
      wr_en = 1'b1;
      wr_data = rd_q ^ val_q;
    end else if (cmd_i.add_b) begin
      wr_en = 1'b1;
      wr_addr = slot_q;
      wr_data = rd_q ^ {val_q[24:0], val_q[31:25]};
    end else if (cmd_i.write_back) begin
      wr_en = 1'b1;
      wr_data = rd_q ^ acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign mixed = acc_q ^ {16'd0, acc_q[31:16]};
  assign prod = val_q * MixMul;

  always_comb begin
    lfsr_d = lfsr_q;
    slot_d = slot_q;
    init_d = init_q;
    scan_d = scan_q;
    acc_d = acc_q;
    val_d = val_q;
    thr_d = thr_q;
    out_d = out_q;
    if (cmd_i.init_step) begin
      init_d = init_q + 1'b1;
      if (init_q >= (SlotW+1)'(4)) begin
        lfsr_d = lfsr_advance(lfsr_q);
      end
    end
    if (cmd_i.latch_in) begin
      val_d = sample_i ^ uptime_ms_i ^ lfsr_advance(lfsr_q);
      if (op_i == OpAdd) begin
        lfsr_d = lfsr_advance(lfsr_q);
      end
    end
    if (cmd_i.add_a) begin
      slot_d = slot_nx;
    end
    if (cmd_i.fold_start) begin
      lfsr_d = lfsr_advance(lfsr_q);
      acc_d = lfsr_advance(lfsr_q);
      // Address 0 is already being read while the fold starts.
      scan_d = SlotW'(1);
    end
    if (cmd_i.fold_acc) begin
      acc_d = acc_q ^ rd_q;
    end
    if (cmd_i.fold_acc || (cmd_i.fold_start == 1'b0 && cmd_i.write_back == 1'b0 &&
        cmd_i.mix1 == 1'b0 && cmd_i.mix2 == 1'b0 && cmd_i.add_a == 1'b0 &&
        cmd_i.add_b == 1'b0 && scan_q != '0)) begin
      scan_d = scan_q + 1'b1;
    end
    if (cmd_i.write_back) begin
      slot_d = slot_nx;
      scan_d = '0;
    end
    if (cmd_i.mix1) begin
      val_d = mixed;
    end
    if (cmd_i.mix2) begin
      acc_d = prod ^ {16'd0, prod[31:16]};
    end
    if (div_done && cmd_i.thr_start == 1'b0 && !cmd_i.mod_start) begin
      thr_d = rem;
    end
    if (cmd_i.out_load) begin
      out_d = (op_i == OpRange) ? (status_o.bound_small ? 32'd0 : rem) : acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LfsrSeed;
      slot_q <= '0;
      init_q <= '0;
      scan_q <= '0;
    end else begin
      lfsr_q <= lfsr_d;
      slot_q <= slot_d;
      init_q <= init_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    val_q <= val_d;
    thr_q <= thr_d;
    out_q <= out_d;
    if (cmd_i.latch_in) begin
      bound_q <= bound_i;
    end
  end

  assign div_start = cmd_i.thr_start | cmd_i.mod_start;
  assign div_a = cmd_i.thr_start ? (32'd0 - bound_q) : acc_q;
  assign div_b = bound_q;

  epr_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  assign status_o.init_done = (init_q == (SlotW+1)'(PoolDepth));
  assign status_o.fold_last = (scan_q == SlotW'(PoolDepth - 1));
  assign status_o.div_done = div_done;
  assign status_o.accept_draw = (acc_q >= thr_q);
  assign status_o.bound_small = (bound_q <= 32'd1);
  assign random_word_o = out_q;
endmodule

>>> hw/rtl/epr_ctrl.sv
// Controller state machine sequencing seeding, add, fold, mix and rejection loops.
// Depends on epr_pkg.
module epr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  epr_pkg::status_t  status_i,
  output epr_pkg::cmd_t     cmd_o,
  output logic [1:0]        op_o
);
  import epr_pkg::*;

  state_e state_q, state_d;
  logic [1:0] op_q;
  logic [DrawW-1:0] draws_q, draws_d;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign op_o = in_acc ? op_i : op_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StInit: if (status_i.init_done) state_d = StIdle;
      StIdle: begin
        if (in_acc) begin
          unique case (op_e'(op_i))
            OpAdd: state_d = StAddA;
            OpRandom: state_d = StFoldStart;
            OpRange: state_d = StThrStart;
            OpNone: state_d = StIdle;
          endcase
        end
      end
      StAddA: state_d = StAddB;
      StAddB: state_d = StIdle;
      StThrStart: state_d = status_i.bound_small ? StOut : StThrWait;
      StThrWait: if (status_i.div_done) state_d = StFoldStart;
      StFoldStart: state_d = StFold;
      StFold: if (status_i.fold_last) state_d = StFoldLast;
      StFoldLast: state_d = StWriteBack;
      StWriteBack: state_d = StMix1;
      StMix1: state_d = StMix2;
      StMix2: state_d = (op_q == OpRange) ? StCheck : StOut;
      StCheck: begin
        if (status_i.accept_draw || draws_q == DrawW'(MaxDraws)) begin
          state_d = StModStart;
        end else begin
          state_d = StFoldStart;
        end
      end
      StModStart: state_d = StModWait;
      StModWait: if (status_i.div_done) state_d = StOut;
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    draws_d = draws_q;
    unique case (state_q)
      StInit: cmd_o.init_step = !status_i.init_done;
      StIdle: begin
        cmd_o.latch_in = in_acc;
        draws_d = '0;
      end
      StAddA: cmd_o.add_a = 1'b1;
      StAddB: cmd_o.add_b = 1'b1;
      StThrStart: begin
        cmd_o.thr_start = !status_i.bound_small;
        cmd_o.out_load = status_i.bound_small;
      end
      StFoldStart: begin
        cmd_o.fold_start = 1'b1;
        draws_d = draws_q + 1'b1;
      end
      StFold: cmd_o.fold_acc = 1'b1;
      StFoldLast: cmd_o.fold_acc = 1'b1;
      StWriteBack: cmd_o.write_back = 1'b1;
      StMix1: cmd_o.mix1 = 1'b1;
      StMix2: begin
        cmd_o.mix2 = 1'b1;
        cmd_o.out_load = (op_q == OpRandom);
      end
      StModStart: cmd_o.mod_start = 1'b1;
      StModWait: cmd_o.out_load = status_i.div_done;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      op_q <= '0;
      draws_q <= '0;
    end else begin
      state_q <= state_d;
      draws_q <= draws_d;
      if (in_acc) begin
        op_q <= op_i;
      end
    end
  end
endmodule

>>> hw/rtl/entropy_pool_rng_core.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid_i/_stall_o op_i, sample_i, uptime_ms_i, bound_i
// out       output     out_valid_o/stall_i random_word_o
// After reset the pool is seeded one word a cycle, all 32 words; input stalls meanwhile.
// An add updates two pool slots; a random word folds the whole pool one read at a time.
// A range request with a bound above 1 adds two remainder passes and a new fold per rejected draw.
// One item is in flight at a time; a result waits in the output register under stall.
// Top level of the entropy pool RNG; depends on epr_pkg, epr_ctrl and epr_datapath.
module entropy_pool_rng_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] sample_i,
  input  logic [31:0] uptime_ms_i,
  input  logic [31:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);
  import epr_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [1:0] op_cur;

  epr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .op_o       (op_cur)
  );

  epr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (op_cur),
    .sample_i     (sample_i),
    .uptime_ms_i  (uptime_ms_i),
    .bound_i      (bound_i),
    .random_word_o(random_word_o)
  );

  // The input side is closed whenever a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input open while result pending");
  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(random_word_o))
    else $error("result changed under stall");
  // Fold and write-back never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.fold_acc && cmd.write_back))
    else $error("fold overlaps write-back");
endmodule

>>> tb/epr_checker.sv
// Scoreboard for entropy_pool_rng_core: watches both channels, predicts words, compares.
// It keeps its own copy of the pool, the LFSR and the slot. It depends on epr_pkg.
module epr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] sample_i,
  input  logic [31:0] uptime_ms_i,
  input  logic [31:0] bound_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] random_word_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  logic [31:0]      pool_q [PoolDepth];
  logic [31:0]      lfsr_q;
  logic [SlotW-1:0] slot_q;
  logic [31:0]      words_due [$];

  assign pending_o = words_due.size();

  function automatic logic [31:0] step_lfsr();
    logic carry;
    carry = lfsr_q[0];
    lfsr_q = lfsr_q >> 1;
    if (carry) begin
      lfsr_q = lfsr_q ^ LfsrTaps;
    end
    return lfsr_q;
  endfunction

  function automatic void seed_pool();
    lfsr_q = LfsrSeed;
    slot_q = '0;
    pool_q[0] = 32'hCAFE_BABE;
    pool_q[1] = 32'h3141_5926;
    pool_q[2] = 32'hABCD_EF01;
    pool_q[3] = 32'h8765_4321;
    for (int i = 4; i < PoolDepth; i++) begin
      pool_q[i] = step_lfsr() ^ (32'(i) * Golden);
    end
  endfunction

  function automatic void mix_sample(logic [31:0] sample, logic [31:0] uptime);
    logic [31:0] v;
    v = sample ^ uptime ^ step_lfsr();
    pool_q[slot_q] ^= v;
    pool_q[SlotW'(slot_q + 1'b1)] ^= {v[24:0], v[31:25]};
    slot_q = slot_q + 1'b1;
  endfunction

  function automatic logic [31:0] fold_and_mix();
    logic [31:0] x;
    x = step_lfsr();
    for (int i = 0; i < PoolDepth; i++) begin
      x ^= pool_q[i];
    end
    pool_q[slot_q] ^= x;
    slot_q = slot_q + 1'b1;
    x ^= x >> 16;
    x = x * MixMul;
    x ^= x >> 16;
    return x;
  endfunction

  function automatic logic [31:0] word_below(logic [31:0] bound);
    logic [31:0] floor_w;
    logic [31:0] r;
    int          n;
    if (bound <= 32'd1) begin
      return '0;
    end
    floor_w = (32'd0 - bound) % bound;
    r = fold_and_mix();
    for (n = 1; n < MaxDraws && r < floor_w; n++) begin
      r = fold_and_mix();
    end
    return r % bound;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_pool();
      words_due.delete();
      errors_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual random_word %08h",
                   $time, random_word_i);
          errors_o <= errors_o + 1;
        end else begin
          if (words_due[0] !== random_word_i) begin
            $display("%0t: random_word mismatch, expected %08h, actual %08h",
                     $time, words_due[0], random_word_i);
            errors_o <= errors_o + 1;
          end
          void'(words_due.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(op_i))
          OpAdd:    mix_sample(sample_i, uptime_ms_i);
          OpRandom: words_due.push_back(fold_and_mix());
          OpRange:  words_due.push_back(word_below(bound_i));
          default:  ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb_entropy_pool_rng_core.sv
// Top of the entropy_pool_rng_core testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on epr_pkg, entropy_pool_rng_core and the epr_checker scoreboard.
module tb_entropy_pool_rng_core;
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OpNone;
  logic [31:0] sample_i = '0;
  logic [31:0] uptime_ms_i = '0;
  logic [31:0] bound_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] random_word_o;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_cycles = 0;
  logic [31:0] uptime_now = 32'd1000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  entropy_pool_rng_core dut (.*);

  epr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .sample_i,
    .uptime_ms_i, .bound_i, .out_valid_i(out_valid_o), .out_stall_i,
    .random_word_i(random_word_o), .errors_o(errors), .pending_o(pending)
  );

  // The receiver stalls at random; a pending hold-off keeps it stalled outright.
  always @(posedge clk_i) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_beat(logic [1:0] op, logic [31:0] sample, logic [31:0] bound);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    uptime_now = uptime_now + $urandom_range(5);
    in_valid_i <= 1'b1;
    op_i <= op;
    sample_i <= sample;
    uptime_ms_i <= ($urandom_range(9) == 0) ? $urandom() : uptime_now;
    bound_i <= bound;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(7))
      0:       return $urandom_range(1);
      1:       return $urandom_range(2, 16);
      2:       return 32'h8000_0000 + $urandom_range(1, 64);
      3:       return 32'hFFFF_FFFF - $urandom_range(3);
      4:       return 32'd1 << $urandom_range(31);
      5:       return $urandom_range(17, 100000);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count);
    int  sent;
    int  pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_beat(OpNone, $urandom(), $urandom());
      end else begin
        if (pick < 38) begin
          send_beat(OpAdd, $urandom(), $urandom());
        end else if (pick < 68) begin
          send_beat(OpRandom, $urandom(), $urandom());
        end else begin
          send_beat(OpRange, $urandom(), pick_bound());
        end
        sent++;
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 64;
    // Directed beats: field extremes, every op, the unused op and the small bounds.
    send_beat(OpAdd, 32'h0000_0000, 32'h0);
    send_beat(OpAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OpRandom, 32'h0, 32'h0);
    send_beat(OpRange, 32'h0, 32'd0);
    send_beat(OpRange, 32'h0, 32'd1);
    send_beat(OpRange, 32'h0, 32'd2);
    send_beat(OpRange, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OpRange, 32'h0, 32'h8000_0000);
    send_beat(OpRange, 32'h0, 32'h8000_0001);
    send_beat(OpRange, 32'h0, 32'hC000_0001);
    send_beat(OpNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OpRandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OpAdd, 32'h5A5A_A5A5, 32'd7);
    send_beat(OpRange, 32'h0, 32'd3);

    // Long receiver hold-off while beats keep coming, so the input backs up.
    holdoff_cycles = 400;
    send_beat(OpRandom, 32'h0, 32'h0);
    send_beat(OpRange, 32'h0, 32'd1000);
    send_beat(OpAdd, 32'h1234_5678, 32'h0);

    // Sender pauses until the last word has come back.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    random_phase(620);
    send_idle_pct = 64;
    recv_idle_pct = 24;
    random_phase(620);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(640);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/epr_pkg.sv
hw/rtl/epr_divider.sv
hw/rtl/epr_datapath.sv
hw/rtl/epr_ctrl.sv
hw/rtl/entropy_pool_rng_core.sv
tb/epr_checker.sv
tb/tb_entropy_pool_rng_core.sv
